// File: hw/rtl/uer_pkg.sv
// shared types and constants of the ultrasonic echo ranger
`default_nettype none

package uer_pkg;

   localparam int COUNT_BITS_DEF = 16;

   localparam logic [15:0] TRIG_PULSE_RESET  = 16'd56;
   localparam logic [15:0] DIST_FACTOR_RESET = 16'd767;

   typedef enum logic [1:0] {
      PH_IDLE       = 2'd0,
      PH_TRIG       = 2'd1,
      PH_WAIT_START = 2'd2,
      PH_WAIT_END   = 2'd3
   } phase_type;

   typedef enum logic {
      REG_TRIG_PULSE  = 1'b0,
      REG_DIST_FACTOR = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic        trig_out;
      phase_type   phase;
      logic        distance_valid;
      logic [15:0] pulse_ticks;
   } stage_type;

endpackage

`default_nettype wire

// File: hw/rtl/uer_core.sv
// trigger and echo capture state machine with echo width stage register
`default_nettype none

module uer_core #(
   parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               trigger_request,
   input  wire logic               echo_level,
   input  wire logic [15:0]        trig_pulse_ticks,
   output uer_pkg::stage_type      stage_ff
);

   localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   uer_pkg::phase_type      phase_ff, phase_in;
   logic [COUNT_BITS-1:0]   tick_ff, tick_in;
   logic [COUNT_BITS-1:0]   start_ff, start_in;
   logic [COUNT_BITS-1:0]   end_ff, end_in;
   logic                    last_echo_ff, last_echo_in;
   logic                    trig_ff, trig_in;

   logic [COUNT_BITS-1:0]   tick_inc;
   logic                    echo_edge;
   logic                    pulse_done;
   logic                    dist_valid;
   logic [COUNT_BITS-1:0]   width_raw;
   logic [CMP_BITS-1:0]     width_wide;
   logic [15:0]             width_sat;
   uer_pkg::stage_type      stage_in;

   assign tick_inc   = tick_ff + 1'b1;
   assign echo_edge  = echo_level ^ last_echo_ff;
   assign pulse_done = (CMP_BITS'(tick_inc) >= CMP_BITS'(trig_pulse_ticks))
                       || (tick_inc == CNT_MAX);

   // next state
   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      trig_in      = trig_ff;
      last_echo_in = echo_level;
      if (trigger_request) begin
         phase_in = uer_pkg::PH_TRIG;
         trig_in  = 1'b1;
         tick_in  = '0;
      end else if (phase_ff == uer_pkg::PH_TRIG) begin
         tick_in = tick_inc;
         if (pulse_done) begin
            trig_in  = 1'b0;
            phase_in = uer_pkg::PH_WAIT_START;
            tick_in  = '0;
         end
      end else begin
         tick_in = tick_inc;
         if (echo_edge) begin
            unique case (phase_ff)
               uer_pkg::PH_WAIT_START: begin
                  start_in = tick_ff;
                  phase_in = uer_pkg::PH_WAIT_END;
               end
               uer_pkg::PH_WAIT_END: begin
                  end_in   = tick_ff;
                  phase_in = uer_pkg::PH_IDLE;
               end
               uer_pkg::PH_IDLE, uer_pkg::PH_TRIG: begin
               end
            endcase
         end
      end
   end

   // outputs of this tick
   always_comb begin
      dist_valid = !trigger_request && (phase_ff == uer_pkg::PH_WAIT_END) && echo_edge;
      // equal captures count as a full wrap
      if (end_in > start_in) begin
         width_raw = end_in - start_in;
      end else begin
         width_raw = CNT_MAX - start_in + end_in;
      end
      width_wide = CMP_BITS'(width_raw);
      if ((width_wide >> 16) != '0) begin
         width_sat = 16'hFFFF;
      end else begin
         width_sat = width_wide[15:0];
      end
      stage_in.trig_out       = trig_in;
      stage_in.phase          = phase_in;
      stage_in.distance_valid = dist_valid;
      stage_in.pulse_ticks    = width_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= uer_pkg::PH_IDLE;
         tick_ff      <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
         last_echo_ff <= 1'b0;
         trig_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         last_echo_ff <= last_echo_in;
         trig_ff      <= trig_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ultrasonic_echo_ranger_top.sv
// ultrasonic echo ranger: words pass stage_ff, then the output register; one word
// per cycle when not stalled; stage one updates the capture state and echo width,
// stage two multiplies the width by dist_factor into the output register
// synchronous reset clears the phase, counter, captures and valids and loads
// trig_pulse_ticks = 56 and dist_factor = 767
`default_nettype none

module ultrasonic_echo_ranger_top #(
   parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_trigger_request,
   input  wire logic        req_echo_level,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_trig_out,
   output logic [1:0]       rsp_phase,
   output logic             rsp_distance_valid,
   output logic [15:0]      rsp_pulse_ticks,
   output logic [31:0]      rsp_distance,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [15:0]             trig_pulse_ff;
   logic [15:0]             dist_factor_ff;
   uer_pkg::reg_index_type  reg_index;
   logic                    cfg_write;

   logic                    stage_valid_ff;
   logic                    stage_advance;
   logic                    accept;
   logic                    out_ready;
   uer_pkg::stage_type      stage_ff;

   logic                    out_valid_ff;
   uer_pkg::stage_type      out_ff;
   logic [31:0]             distance_ff, distance_in;

   assign pready    = 1'b1;
   assign reg_index = uer_pkg::reg_index_type'(paddr[2]);
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      unique case (reg_index)
         uer_pkg::REG_TRIG_PULSE:  prdata = {16'h0000, trig_pulse_ff};
         uer_pkg::REG_DIST_FACTOR: prdata = {16'h0000, dist_factor_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_pulse_ff  <= uer_pkg::TRIG_PULSE_RESET;
         dist_factor_ff <= uer_pkg::DIST_FACTOR_RESET;
      end else if (cfg_write) begin
         unique case (reg_index)
            uer_pkg::REG_TRIG_PULSE:  trig_pulse_ff  <= pwdata[15:0];
            uer_pkg::REG_DIST_FACTOR: dist_factor_ff <= pwdata[15:0];
         endcase
      end
   end

   // two-stage word pipeline, each stage moves when the one after it has room
   assign out_ready     = !out_valid_ff || !rsp_stall;
   assign stage_advance = !stage_valid_ff || out_ready;
   assign req_stall     = !stage_advance;
   assign accept        = req_valid && stage_advance;

   uer_core #(
      .COUNT_BITS(COUNT_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .trigger_request  (req_trigger_request),
      .echo_level       (req_echo_level),
      .trig_pulse_ticks (trig_pulse_ff),
      .stage_ff         (stage_ff)
   );

   assign distance_in = 32'(stage_ff.pulse_ticks * dist_factor_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (stage_advance) begin
            stage_valid_ff <= req_valid;
         end
         if (out_ready) begin
            out_valid_ff <= stage_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && stage_valid_ff) begin
         out_ff      <= stage_ff;
         distance_ff <= distance_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_trig_out       = out_ff.trig_out;
   assign rsp_phase          = out_ff.phase;
   assign rsp_distance_valid = out_ff.distance_valid;
   assign rsp_pulse_ticks    = out_ff.pulse_ticks;
   assign rsp_distance       = distance_ff;

endmodule

`default_nettype wire
